### rtl/pscomp_pkg.sv
// ----------------------------------------------------------------------------
// pscomp_pkg
// types and constants shared by the premultiplied src-over compositor
// ----------------------------------------------------------------------------
package pscomp_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_MODE         = 2'd0,
        CFG_FILL_COLOR   = 2'd1,
        CFG_GLOBAL_ALPHA = 2'd2
    } cfg_index_t;

    // compositing mode
    typedef enum logic {
        MODE_BITMAP = 1'b0,
        MODE_FILL   = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] fill_color;
        logic [7:0]  global_alpha;
    } cfg_t;

    // per stage load enables of the channel pipeline
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } pipe_en_t;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0]  CHAN_MAX     = 8'd255;

    // 255 * 255, full scale of an alpha product
    localparam logic [15:0] FULL_SCALE   = 16'd65025;

    // rounding divide: floor((2n + 65025) / 130050)
    localparam logic [16:0] DIVISOR      = 17'd130050;
    // floor(2^34 / 130050), the estimate is low by at most one
    localparam logic [17:0] DIV_RECIP    = 18'd132102;
    localparam int          DIV_SHIFT    = 34;

endpackage

### rtl/pscomp_cfg.sv
// ----------------------------------------------------------------------------
// pscomp_cfg
// configuration registers: mode, fill color and global alpha
// ----------------------------------------------------------------------------
module pscomp_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output pscomp_pkg::cfg_t    cfg
);

    pscomp_pkg::mode_t mode_reg;
    logic [31:0]       fill_reg;
    logic [7:0]        galpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pscomp_pkg::MODE_BITMAP;
            fill_reg   <= 32'd0;
            galpha_reg <= 8'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pscomp_pkg::CFG_MODE:
                begin
                    mode_reg <= pscomp_pkg::mode_t'(cfg_data[0]);
                end
                pscomp_pkg::CFG_FILL_COLOR:
                begin
                    fill_reg <= cfg_data;
                end
                pscomp_pkg::CFG_GLOBAL_ALPHA:
                begin
                    galpha_reg <= cfg_data[7:0];
                end
                default:
                begin
                    // unknown index, ignored
                end
            endcase
        end
    end

    assign cfg.mode         = mode_reg;
    assign cfg.fill_color   = fill_reg;
    assign cfg.global_alpha = galpha_reg;

endmodule

### rtl/pscomp_chan.sv
// ----------------------------------------------------------------------------
// pscomp_chan
// one color channel: products, numerator, reciprocal divide, correct and clamp
// ----------------------------------------------------------------------------
module pscomp_chan
(
    input  logic                    clk,
    input  pscomp_pkg::pipe_en_t    en,
    input  logic [7:0]              cs,
    input  logic [7:0]              cd,
    input  logic [7:0]              as_in,
    input  logic [7:0]              g,
    input  logic                    byp,
    input  logic [7:0]              byp_byte,
    output logic [7:0]              out_byte
);

    // stage a: source and alpha products
    logic [15:0] csg_a_reg;
    logic [15:0] ag_a_reg;
    logic [7:0]  cd_a_reg;
    logic        byp_a_reg;
    logic [7:0]  bypb_a_reg;

    // stage b: rounded numerator 2n + 65025
    logic [23:0] t1;
    logic [23:0] t2;
    logic [24:0] n_sum;
    logic [25:0] m_next;
    logic [25:0] m_b_reg;
    logic        byp_b_reg;
    logic [7:0]  bypb_b_reg;

    // stage c: quotient estimate
    logic [43:0] prod;
    logic [8:0]  qest_next;
    logic [8:0]  qest_c_reg;
    logic [25:0] m_c_reg;
    logic        byp_c_reg;
    logic [7:0]  bypb_c_reg;

    // stage d: correction and clamp
    logic [26:0] qm;
    logic [26:0] rem;
    logic [8:0]  q;
    logic [7:0]  sat;
    logic [7:0]  out_reg;
    logic [7:0]  out_next;

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            csg_a_reg  <= 16'(cs) * 16'(g);
            ag_a_reg   <= 16'(as_in) * 16'(g);
            cd_a_reg   <= cd;
            byp_a_reg  <= byp;
            bypb_a_reg <= byp_byte;
        end
    end

    always_comb
    begin
        t1     = {csg_a_reg, 8'd0} - 24'(csg_a_reg);
        t2     = 24'(pscomp_pkg::FULL_SCALE - ag_a_reg) * 24'(cd_a_reg);
        n_sum  = 25'(t1) + 25'(t2);
        m_next = {n_sum, 1'b0} + 26'(pscomp_pkg::FULL_SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            m_b_reg    <= m_next;
            byp_b_reg  <= byp_a_reg;
            bypb_b_reg <= bypb_a_reg;
        end
    end

    always_comb
    begin
        prod      = 44'(m_b_reg) * 44'(pscomp_pkg::DIV_RECIP);
        qest_next = prod[pscomp_pkg::DIV_SHIFT +: 9];
    end

    always_ff @(posedge clk)
    begin
        if (en.c)
        begin
            qest_c_reg <= qest_next;
            m_c_reg    <= m_b_reg;
            byp_c_reg  <= byp_b_reg;
            bypb_c_reg <= bypb_b_reg;
        end
    end

    always_comb
    begin
        qm  = 27'(qest_c_reg) * 27'(pscomp_pkg::DIVISOR);
        rem = 27'(m_c_reg) - qm;
        q   = qest_c_reg + 9'(rem >= 27'(pscomp_pkg::DIVISOR));
        sat = q[8] ? pscomp_pkg::CHAN_MAX : q[7:0];
        out_next = byp_c_reg ? bypb_c_reg : sat;
    end

    always_ff @(posedge clk)
    begin
        if (en.d)
        begin
            out_reg <= out_next;
        end
    end

    assign out_byte = out_reg;

endmodule

### rtl/premult_src_over_compositor.sv
// ----------------------------------------------------------------------------
// premult_src_over_compositor
// premultiplied argb8888 source-over blend, without a stall one pixel per clock
// ----------------------------------------------------------------------------
// usage
//   input stream: one word per pixel pair, dest in tdata[31:0],
//   source in tdata[63:32]; output stream: the composited pixel
//   config port: cfg_index 0 mode, 1 fill color, 2 global alpha;
//   cfg_ready is always high, write only while the pipeline is empty
//   bitmap mode blends the source with global alpha g/255, fill mode
//   blends the fill color; an opaque fill is copied, a clear fill
//   passes the destination
//   an accepted pixel passes through five register stages in order
//   (operand select, 8x8 products, numerator, reciprocal multiply,
//   remainder correct and clamp); throughput is one pixel per cycle
//   while the receiver keeps up
//   reset: pipeline empties, mode bitmap, fill 0, global alpha 255
//   a receiver stall holds the output word; each stage keeps taking
//   words until it and every stage after it are full
// ----------------------------------------------------------------------------
module premult_src_over_compositor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // dest_pixel, source_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pscomp_pkg::cfg_t     cfg;
    pscomp_pkg::pipe_en_t en;
    logic                 en_s;

    logic v_s_reg;
    logic v_a_reg;
    logic v_b_reg;
    logic v_c_reg;
    logic v_d_reg;

    logic [31:0] dst;
    logic [31:0] src;

    logic [31:0] src_next;
    logic [7:0]  g_next;
    logic        byp_next;
    logic [31:0] bypv_next;

    logic [31:0] src_s_reg;
    logic [31:0] dst_s_reg;
    logic [7:0]  g_s_reg;
    logic        byp_s_reg;
    logic [31:0] bypv_s_reg;

    logic [3:0][7:0] res_bytes;

    assign dst = s_axis_tdata[31:0];
    assign src = s_axis_tdata[63:32];

    pscomp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage enables, a stage loads when empty or when the next one moves
    always_comb
    begin
        en.d = !v_d_reg || m_axis_tready;
        en.c = !v_c_reg || en.d;
        en.b = !v_b_reg || en.c;
        en.a = !v_a_reg || en.b;
        en_s = !v_s_reg || en.a;
    end

    assign s_axis_tready = en_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s_reg <= 1'b0;
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else
        begin
            if (en_s)
            begin
                v_s_reg <= s_axis_tvalid;
            end
            if (en.a)
            begin
                v_a_reg <= v_s_reg;
            end
            if (en.b)
            begin
                v_b_reg <= v_a_reg;
            end
            if (en.c)
            begin
                v_c_reg <= v_b_reg;
            end
            if (en.d)
            begin
                v_d_reg <= v_c_reg;
            end
        end
    end

    // operand select
    always_comb
    begin
        src_next  = src;
        g_next    = cfg.global_alpha;
        byp_next  = 1'b0;
        bypv_next = dst;
        if (cfg.mode == pscomp_pkg::MODE_FILL)
        begin
            src_next = cfg.fill_color;
            g_next   = pscomp_pkg::ALPHA_OPAQUE;
            if (cfg.fill_color[31:24] == pscomp_pkg::ALPHA_OPAQUE)
            begin
                byp_next  = 1'b1;
                bypv_next = cfg.fill_color;
            end
            else if (cfg.fill_color[31:24] == pscomp_pkg::ALPHA_CLEAR)
            begin
                byp_next  = 1'b1;
                bypv_next = dst;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s)
        begin
            src_s_reg  <= src_next;
            dst_s_reg  <= dst;
            g_s_reg    <= g_next;
            byp_s_reg  <= byp_next;
            bypv_s_reg <= bypv_next;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_chan
        pscomp_chan u_chan
        (
            .clk      (clk),
            .en       (en),
            .cs       (src_s_reg[8*i +: 8]),
            .cd       (dst_s_reg[8*i +: 8]),
            .as_in    (src_s_reg[31:24]),
            .g        (g_s_reg),
            .byp      (byp_s_reg),
            .byp_byte (bypv_s_reg[8*i +: 8]),
            .out_byte (res_bytes[i])
        );
    end

    assign m_axis_tvalid = v_d_reg;
    assign m_axis_tdata  = res_bytes;

endmodule

### rtl/pscomp_checker.sv
// ----------------------------------------------------------------------------
// pscomp_checker
// port level checks on the compositor, bound to the top level
// ----------------------------------------------------------------------------
module pscomp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);

    // stalled word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped during stall");

    // stalled word keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed during stall");

    // an empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with free output stage");

    // an accepted word reaches the output when the receiver keeps up
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready, 5)
        && $past(m_axis_tready, 4) && $past(m_axis_tready, 3)
        && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
        && $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3)
        && $past(rst_n, 2) && $past(rst_n, 1)
        |-> m_axis_tvalid)
        else $error("output word late");

endmodule

bind premult_src_over_compositor pscomp_checker u_pscomp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/pixel_blend_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_blend_checker
// watches the config, input and output channels of the compositor, keeps a
// shadow copy of the registers, predicts every composited pixel and
// compares each output word with the oldest prediction in order
// ----------------------------------------------------------------------------
module pixel_blend_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // dest_pixel, source_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // out_pixel
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);

    pscomp_pkg::mode_t shadow_mode;
    logic [31:0]       shadow_fill;
    logic [7:0]        shadow_alpha;
    logic [31:0]       expected_pixels[$];
    int                mismatches = 0;

    function automatic logic [7:0] mix_channel(input logic [7:0] cs, input logic [7:0] cd,
                                               input logic [7:0] as, input logic [7:0] g);
        logic [63:0] num;
        logic [63:0] quot;
        begin
            num  = 64'(cs) * 64'(g) * 64'd255
                 + (64'(pscomp_pkg::FULL_SCALE) - 64'(as) * 64'(g)) * 64'(cd);
            quot = (64'd2 * num + 64'(pscomp_pkg::FULL_SCALE)) / 64'(pscomp_pkg::DIVISOR);
            mix_channel = (quot > 64'(pscomp_pkg::CHAN_MAX)) ? pscomp_pkg::CHAN_MAX
                                                              : quot[7:0];
        end
    endfunction

    function automatic logic [31:0] src_over_pixel(input logic [31:0] dst,
                                                   input logic [31:0] src,
                                                   input logic [7:0]  g);
        logic [31:0] res;
        begin
            res = '0;
            for (int sh = 0; sh < 32; sh += 8)
                res[sh +: 8] = mix_channel(src[sh +: 8], dst[sh +: 8], src[31:24], g);
            src_over_pixel = res;
        end
    endfunction

    function automatic logic [31:0] predict_out_pixel(input logic [31:0] dst,
                                                      input logic [31:0] src);
        begin
            if (shadow_mode == pscomp_pkg::MODE_FILL)
            begin
                if (shadow_fill[31:24] == pscomp_pkg::ALPHA_OPAQUE)
                    predict_out_pixel = shadow_fill;
                else if (shadow_fill[31:24] == pscomp_pkg::ALPHA_CLEAR)
                    predict_out_pixel = dst;
                else
                    predict_out_pixel = src_over_pixel(dst, shadow_fill,
                                                       pscomp_pkg::ALPHA_OPAQUE);
            end
            else
                predict_out_pixel = src_over_pixel(dst, src, shadow_alpha);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            shadow_mode  = pscomp_pkg::MODE_BITMAP;
            shadow_fill  = '0;
            shadow_alpha = pscomp_pkg::ALPHA_OPAQUE;
            outstanding <= 0;
            fail_count  <= mismatches;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(predict_out_pixel(s_axis_tdata[31:0],
                                                            s_axis_tdata[63:32]));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pscomp_pkg::CFG_MODE:
                        shadow_mode  = pscomp_pkg::mode_t'(cfg_data[0]);
                    pscomp_pkg::CFG_FILL_COLOR:
                        shadow_fill  = cfg_data;
                    pscomp_pkg::CFG_GLOBAL_ALPHA:
                        shadow_alpha = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("out_pixel: expected none, actual %08h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    if (m_axis_tdata !== expected_pixels[0])
                    begin
                        $error("out_pixel: expected %08h, actual %08h",
                               expected_pixels[0], m_axis_tdata);
                        mismatches++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            outstanding <= expected_pixels.size();
            fail_count  <= mismatches;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the premultiplied src-over compositor: directed
// corner pixels under the reset and edge register settings, then random
// pixel pairs over several register settings with random gaps on both
// streams and one long output stall
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int         CYCLE_LIMIT      = 500000;
    localparam int         RANDOM_PHASES    = 8;
    localparam int         PIXELS_PER_PHASE = 104;
    localparam int         LONG_HOLD        = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // dest_pixel, source_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // out_pixel
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          send_quiet  = 0;
    bit          hold_armed  = 1'b0;

    premult_src_over_compositor u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_blend_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and runs with none at all
    task automatic pick_gap(inout int quiet, output int n);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (quiet > 0)
            begin
                quiet--;
                n = 0;
            end
            else if (r < 4)
            begin
                quiet = $urandom_range(20, 60);
                n = 0;
            end
            else if (r < 50)
                n = 0;
            else if (r < 85)
                n = $urandom_range(1, 3);
            else if (r < 97)
                n = $urandom_range(4, 10);
            else
                n = $urandom_range(20, 60);
        end
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        logic [7:0]  a;
        int          r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                a = 8'($urandom_range(0, 255));
                px[31:24] = a;
                for (int sh = 0; sh < 24; sh += 8)
                    px[sh +: 8] = 8'($urandom_range(0, a));
            end
            else if (r < 85)
                px = $urandom;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       px = 32'h0000_0000;
                    1:       px = 32'hFFFF_FFFF;
                    2:       px = 32'hFF00_0000;
                    default: px = 32'h00FF_FFFF;
                endcase
            end
            rand_pixel = px;
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_pixel(input logic [31:0] dst, input logic [31:0] src);
        int gap;
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {src, dst};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            pick_gap(send_quiet, gap);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    // receiver: random ready pattern, one long stall once the random part starts
    initial
    begin
        int  gap;
        int  quiet;
        bit  hold_done;
        quiet     = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            pick_gap(quiet, gap);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [31:0] fill;
        logic [7:0]  ga;
        logic [31:0] dst;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = pscomp_pkg::CFG_MODE;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bitmap mode, opaque global alpha
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'h8040_2010, 32'hFF11_2233);
        send_pixel(32'hFFFF_FFFF, 32'h00FF_FFFF);
        send_pixel(32'h8080_8080, 32'h4040_4040);
        drain();

        // zero global alpha passes the destination
        write_reg(pscomp_pkg::CFG_GLOBAL_ALPHA, 32'hFFFF_FF00);
        send_pixel(32'h1234_5678, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h8040_2010);
        drain();

        write_reg(pscomp_pkg::CFG_GLOBAL_ALPHA, 32'h0000_0080);
        send_pixel(32'hFFFF_FFFF, 32'h8080_8080);
        send_pixel(32'h4020_1000, 32'hFF7F_3F1F);
        drain();

        // write beyond the register list is ignored
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        send_pixel(32'h2020_2020, 32'h8080_8080);
        drain();

        // opaque fill copies the color
        write_reg(pscomp_pkg::CFG_MODE, 32'hFFFF_FFFF);
        write_reg(pscomp_pkg::CFG_FILL_COLOR, 32'hFF12_3456);
        send_pixel(32'h0000_0000, 32'h8765_4321);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // clear fill passes the destination
        write_reg(pscomp_pkg::CFG_FILL_COLOR, 32'h00FF_FFFF);
        send_pixel(32'h8040_2010, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        write_reg(pscomp_pkg::CFG_FILL_COLOR, 32'h8040_2010);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // fill channels above alpha saturate
        write_reg(pscomp_pkg::CFG_FILL_COLOR, 32'h7FFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h1111_1111);
        send_pixel(32'h8080_8080, 32'h0000_0000);
        drain();

        hold_armed = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            ga = 8'($urandom_range(0, 255));
            case (p)
                0:       ga = 8'd0;
                2:       ga = 8'd255;
                4:       ga = 8'd1;
                default: ;
            endcase
            fill = (($urandom_range(0, 1) == 0) ? rand_pixel() : $urandom);
            case (p)
                1:       fill[31:24] = 8'd255;
                3:       fill[31:24] = 8'd0;
                5:       fill[31:24] = 8'd1;
                7:       fill[31:24] = 8'd254;
                default: ;
            endcase
            write_reg(pscomp_pkg::CFG_MODE,
                      {31'($urandom_range(0, 32'h7FFF_FFFF)), p[0]});
            write_reg(pscomp_pkg::CFG_FILL_COLOR, fill);
            write_reg(pscomp_pkg::CFG_GLOBAL_ALPHA,
                      {24'($urandom_range(0, 32'h00FF_FFFF)), ga});
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                dst = rand_pixel();
                send_pixel(dst, rand_pixel());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
